// ----- design/spdf_pkg.sv -----
// Package: constants, state codes and shared types of the stuffed packet deframer.
`default_nettype none
package spdf_pkg;

    // Byte and field widths
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 16;
    localparam int COUNT_W   = 17;
    localparam int STATE_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 8;

    // Framing bytes
    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h33;
    localparam logic [BYTE_W-1:0] FILLER_BYTE = 8'hAA;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_BODY     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END_GOOD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END_BAD  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RAW      = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_LAST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_TRANS  = 2'd2;

    // Deframer states
    localparam logic [STATE_W-1:0] ST_SYNC1  = 4'd0;
    localparam logic [STATE_W-1:0] ST_SYNC2  = 4'd1;
    localparam logic [STATE_W-1:0] ST_LEN_LO = 4'd2;
    localparam logic [STATE_W-1:0] ST_BLANK1 = 4'd3;
    localparam logic [STATE_W-1:0] ST_LEN_HI = 4'd4;
    localparam logic [STATE_W-1:0] ST_BLANK2 = 4'd5;
    localparam logic [STATE_W-1:0] ST_BODY   = 4'd6;
    localparam logic [STATE_W-1:0] ST_FILLER = 4'd7;
    localparam logic [STATE_W-1:0] ST_CHECK  = 4'd8;

    // One result item plus its valid flag
    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [INDEX_W-1:0]  byte_index;
    } result_t;

    // Configuration write bundle
    typedef struct packed {
        logic                 wr_en;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DW-1:0]    wdata;
    } cfg_wr_t;

endpackage
`default_nettype wire

// ----- design/sync_stuffed_packet_deframer.sv -----
// Top level: input register, deframer state machine and result register.
//
// Usage:
//   Input channel s_valid/s_ready/s_rx_byte carries one serial byte per item.
//   Result channel m_valid/m_ready carries m_kind, m_data_byte, m_byte_index:
//   body bytes with their index, frame end good/bad with the body count,
//   and raw bytes tagged with the raw transaction id.
//   Configuration: cfg_wr_en, cfg_index, cfg_wdata write one register per
//   cycle; the user must write only while the block is idle (not enforced).
// Timing:
//   An accepted item waits in the input register and is processed there when
//   the result register is free or being emptied; its result, if any, is
//   loaded into the result register and shows on the result channel from it.
//   Throughput is one item per cycle while m_ready keeps the result moving.
// Reset:
//   Hunting for sync, counters and registers cleared, raw mode off, both
//   internal registers empty.
// Stall:
//   While m_ready is low with a result held, one more item is taken into
//   the input register, then s_ready drops until the result is taken.
`default_nettype none
module sync_stuffed_packet_deframer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [spdf_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [spdf_pkg::KIND_W-1:0]         m_kind,
    output logic [spdf_pkg::BYTE_W-1:0]         m_data_byte,
    output logic [spdf_pkg::INDEX_W-1:0]        m_byte_index,
    input  wire logic                           cfg_wr_en,
    input  wire logic [spdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spdf_pkg::CFG_DW-1:0]    cfg_wdata
);
    import spdf_pkg::*;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [BYTE_W-1:0]  out_data_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               step;
    result_t            res;
    cfg_wr_t            cfg;

    assign cfg  = '{wr_en: cfg_wr_en, index: cfg_index, wdata: cfg_wdata};
    assign step = in_valid_reg && (!out_valid_reg || m_ready);

    assign s_ready      = !in_valid_reg || step;
    assign m_valid      = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_data_byte  = out_data_reg;
    assign m_byte_index = out_index_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    spdf_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res.valid) begin
            out_kind_reg  <= res.kind;
            out_data_reg  <= res.data_byte;
            out_index_reg <= res.byte_index;
        end
    end

    // An empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    // A held item keeps its byte until it is processed
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending item lost");

    // A produced result lands in the result register
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.valid) |=> out_valid_reg)
        else $error("result dropped");

endmodule
`default_nettype wire

// ----- design/spdf_fsm.sv -----
// Deframer state machine: framing state, counters, checksum and raw-mode registers.
`default_nettype none
module spdf_fsm (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire spdf_pkg::cfg_wr_t           cfg,
    input  wire logic                        step,
    input  wire logic [spdf_pkg::BYTE_W-1:0] rx_byte,
    output spdf_pkg::result_t                res
);
    import spdf_pkg::*;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [INDEX_W-1:0] frame_length_reg, frame_length_next;
    logic [COUNT_W-1:0] counted_bytes_reg, counted_bytes_next;
    logic [BYTE_W-1:0]  running_sum_reg, running_sum_next;
    logic [INDEX_W-1:0] stored_index_reg, stored_index_next;
    logic               raw_active_reg, raw_active_next;
    logic               raw_last_reg, raw_last_next;
    logic [BYTE_W-1:0]  raw_trans_reg, raw_trans_next;

    logic [COUNT_W-1:0] count_inc;
    logic [BYTE_W-1:0]  sum_inc;
    logic               len_reached;

    assign count_inc   = counted_bytes_reg + COUNT_W'(1);
    assign sum_inc     = running_sum_reg + rx_byte;
    assign len_reached = count_inc >= {1'b0, frame_length_reg};

    // Per-byte state update and configuration register writes
    always_comb begin
        state_next         = state_reg;
        frame_length_next  = frame_length_reg;
        counted_bytes_next = counted_bytes_reg;
        running_sum_next   = running_sum_reg;
        stored_index_next  = stored_index_reg;
        raw_active_next    = raw_active_reg;
        raw_last_next      = raw_last_reg;
        raw_trans_next     = raw_trans_reg;
        res                = '0;

        if (step) begin
            unique case (state_reg)
                ST_SYNC2: begin
                    state_next = (rx_byte == SYNC_SECOND) ? ST_LEN_LO : ST_SYNC1;
                end
                ST_LEN_LO: begin
                    frame_length_next = {8'd0, rx_byte};
                    state_next        = ST_BLANK1;
                end
                ST_BLANK1: begin
                    state_next = (rx_byte != '0) ? ST_SYNC1 : ST_LEN_HI;
                end
                ST_LEN_HI: begin
                    frame_length_next = {rx_byte, frame_length_reg[BYTE_W-1:0]};
                    state_next        = ST_BLANK2;
                end
                ST_BLANK2: begin
                    if (rx_byte != '0 || frame_length_reg == '0) begin
                        state_next = ST_SYNC1;
                    end else begin
                        state_next         = ST_BODY;
                        running_sum_next   = '0;
                        counted_bytes_next = '0;
                        stored_index_next  = '0;
                    end
                end
                ST_BODY: begin
                    res.valid          = 1'b1;
                    res.kind           = KIND_BODY;
                    res.data_byte      = rx_byte;
                    res.byte_index     = stored_index_reg;
                    stored_index_next  = stored_index_reg + INDEX_W'(1);
                    counted_bytes_next = count_inc;
                    running_sum_next   = sum_inc;
                    if (rx_byte == SYNC_FIRST) begin
                        state_next = ST_FILLER;
                    end else if (len_reached) begin
                        state_next = ST_CHECK;
                    end
                end
                ST_FILLER: begin
                    running_sum_next   = sum_inc;
                    counted_bytes_next = count_inc;
                    if (rx_byte != FILLER_BYTE) begin
                        state_next = ST_SYNC1;
                    end else if (len_reached) begin
                        state_next = ST_CHECK;
                    end else begin
                        state_next = ST_BODY;
                    end
                end
                ST_CHECK: begin
                    res.valid      = 1'b1;
                    res.kind       = (running_sum_reg == rx_byte) ? KIND_END_GOOD
                                                                  : KIND_END_BAD;
                    res.byte_index = stored_index_reg;
                    state_next     = ST_SYNC1;
                end
                default: begin
                    // Hunting for the first sync byte, or passing raw bytes in raw mode; unknown codes land here too
                    state_next = ST_SYNC1;
                    if (raw_active_reg) begin
                        if (raw_last_reg) begin
                            raw_active_next = 1'b0;
                            raw_last_next   = 1'b0;
                        end
                        res.valid      = 1'b1;
                        res.kind       = KIND_RAW;
                        res.data_byte  = rx_byte;
                        res.byte_index = {8'd0, raw_trans_reg};
                    end else if (rx_byte == SYNC_FIRST) begin
                        state_next = ST_SYNC2;
                    end
                end
            endcase
        end

        // Register writes must arrive only while idle; the block itself does not enforce it
        if (cfg.wr_en) begin
            unique case (cfg.index)
                CFG_RAW_MODE:  raw_active_next = cfg.wdata[0];
                CFG_RAW_LAST:  raw_last_next   = cfg.wdata[0];
                CFG_RAW_TRANS: raw_trans_next  = cfg.wdata;
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_SYNC1;
            frame_length_reg  <= '0;
            counted_bytes_reg <= '0;
            running_sum_reg   <= '0;
            stored_index_reg  <= '0;
            raw_active_reg    <= 1'b0;
            raw_last_reg      <= 1'b0;
            raw_trans_reg     <= '0;
        end else begin
            state_reg         <= state_next;
            frame_length_reg  <= frame_length_next;
            counted_bytes_reg <= counted_bytes_next;
            running_sum_reg   <= running_sum_next;
            stored_index_reg  <= stored_index_next;
            raw_active_reg    <= raw_active_next;
            raw_last_reg      <= raw_last_next;
            raw_trans_reg     <= raw_trans_next;
        end
    end

    // Inside the body the count stays below the length
    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BODY) |-> (counted_bytes_reg < {1'b0, frame_length_reg}))
        else $error("body count reached frame length");

    // A filler never follows more than the full length
    a_filler_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILLER) |-> (counted_bytes_reg <= {1'b0, frame_length_reg}))
        else $error("filler count beyond frame length");

    // A non-zero blank drops back to hunting
    a_blank_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !cfg.wr_en && (state_reg == ST_BLANK1 || state_reg == ST_BLANK2)
         && rx_byte != '0) |=> (state_reg == ST_SYNC1))
        else $error("non-zero blank did not abort");

endmodule
`default_nettype wire

// ----- verif/spdf_checker.sv -----
// Checker: follows the deframer channels, predicts each result and compares it on arrival.
module spdf_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic [spdf_pkg::BYTE_W-1:0]    s_rx_byte,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic [spdf_pkg::KIND_W-1:0]    m_kind,
    input  wire logic [spdf_pkg::BYTE_W-1:0]    m_data_byte,
    input  wire logic [spdf_pkg::INDEX_W-1:0]   m_byte_index,
    input  wire logic                           cfg_wr_en,
    input  wire logic [spdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spdf_pkg::CFG_DW-1:0]    cfg_wdata,
    output int                                  mismatch_count,
    output int                                  awaited_count
);
    import spdf_pkg::*;

    // Shadow of the deframer state and its registers
    logic [STATE_W-1:0] fsm_state;
    logic [INDEX_W-1:0] frame_len;
    logic [COUNT_W-1:0] byte_count;
    logic [BYTE_W-1:0]  body_sum;
    logic [INDEX_W-1:0] body_index;
    logic               raw_on;
    logic               last_ack_armed;
    logic [BYTE_W-1:0]  raw_tid;

    result_t awaited_results[$];
    result_t want;
    int      err_total;

    task automatic await_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                                input logic [INDEX_W-1:0] idx);
        result_t r;
        r.valid      = 1'b1;
        r.kind       = kind;
        r.data_byte  = data;
        r.byte_index = idx;
        awaited_results.insert(awaited_results.size(), r);
    endtask

    // One received byte through the hunt / header / body / checksum machine
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        case (fsm_state)
            ST_SYNC2: fsm_state = (b == SYNC_SECOND) ? ST_LEN_LO : ST_SYNC1;
            ST_LEN_LO: begin
                frame_len = {8'h00, b};
                fsm_state = ST_BLANK1;
            end
            ST_BLANK1: fsm_state = (b != 8'h00) ? ST_SYNC1 : ST_LEN_HI;
            ST_LEN_HI: begin
                frame_len = {b, frame_len[7:0]};
                fsm_state = ST_BLANK2;
            end
            ST_BLANK2: begin
                if (b != 8'h00 || frame_len == '0) begin
                    fsm_state = ST_SYNC1;
                end else begin
                    fsm_state  = ST_BODY;
                    body_sum   = '0;
                    byte_count = '0;
                    body_index = '0;
                end
            end
            ST_BODY: begin
                await_result(KIND_BODY, b, body_index);
                body_index = body_index + 1'b1;
                byte_count = byte_count + 1'b1;
                body_sum   = body_sum + b;
                if (b == SYNC_FIRST)
                    fsm_state = ST_FILLER;
                else if (byte_count >= {1'b0, frame_len})
                    fsm_state = ST_CHECK;
            end
            ST_FILLER: begin
                // filler counts toward length and sum but is not emitted
                body_sum   = body_sum + b;
                byte_count = byte_count + 1'b1;
                if (b != FILLER_BYTE)
                    fsm_state = ST_SYNC1;
                else if (byte_count >= {1'b0, frame_len})
                    fsm_state = ST_CHECK;
                else
                    fsm_state = ST_BODY;
            end
            ST_CHECK: begin
                await_result((body_sum == b) ? KIND_END_GOOD : KIND_END_BAD, 8'h00, body_index);
                fsm_state = ST_SYNC1;
            end
            default: begin
                // hunting: raw bypass wins over sync detection
                fsm_state = ST_SYNC1;
                if (raw_on) begin
                    if (last_ack_armed) begin
                        raw_on         = 1'b0;
                        last_ack_armed = 1'b0;
                    end
                    await_result(KIND_RAW, b, {8'h00, raw_tid});
                end else if (b == SYNC_FIRST) begin
                    fsm_state = ST_SYNC2;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fsm_state      = ST_SYNC1;
            frame_len      = '0;
            byte_count     = '0;
            body_sum       = '0;
            body_index     = '0;
            raw_on         = 1'b0;
            last_ack_armed = 1'b0;
            raw_tid        = '0;
            err_total      = 0;
            awaited_results.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RAW_MODE:  raw_on = cfg_wdata[0];
                    CFG_RAW_LAST:  last_ack_armed = cfg_wdata[0];
                    CFG_RAW_TRANS: raw_tid = cfg_wdata;
                    default: ;
                endcase
            end
            // result side: compare with the oldest prediction
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: got kind %0d data %02h index %0d",
                             $time, m_kind, m_data_byte, m_byte_index);
                    err_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_kind !== want.kind || m_data_byte !== want.data_byte ||
                        m_byte_index !== want.byte_index) begin
                        $display("%0t: result mismatch: expected kind %0d data %02h index %0d, %s",
                                 $time, want.kind, want.data_byte, want.byte_index, "got");
                        $display("%0t:   got kind %0d data %02h index %0d",
                                 $time, m_kind, m_data_byte, m_byte_index);
                        err_total++;
                    end
                end
            end
            // input side
            if (s_valid && s_ready)
                deframe_byte(s_rx_byte);
        end
        mismatch_count <= err_total;
        awaited_count  <= awaited_results.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top: clock, reset, byte stimulus, result-side stalls and the verdict.
module tb_top;
    import spdf_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_BAD_SYNC2,
        FLAW_BLANK1,
        FLAW_BLANK2,
        FLAW_ZERO_LEN,
        FLAW_NO_FILLER
    } frame_flaw_e;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [KIND_W-1:0]    m_kind;
    logic [BYTE_W-1:0]    m_data_byte;
    logic [INDEX_W-1:0]   m_byte_index;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DW-1:0]    cfg_wdata = '0;

    int mismatch_count;
    int awaited_count;

    logic [BYTE_W-1:0] frame_q[$];
    int burst_left = 0;
    int sent_items = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int ready_phase = 0;

    always #1 aclk = ~aclk;

    sync_stuffed_packet_deframer DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    spdf_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_byte_index   (m_byte_index),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    // Result side: stall patterns that change every so often, plus requested long hold-offs
    always @(posedge aclk) begin
        ready_phase++;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = $urandom_range(40, 80);
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (ready_phase % 3 != 0);
            endcase
        end
    end

    // Offer one byte and wait for it to be taken; bursts with random gaps in between
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_queued(input int from, input int upto);
        for (int i = from; i < upto; i++)
            send_byte(frame_q[i]);
        sent_items += upto - from;
    endtask

    // Sender stops until every predicted result is back and the pipeline has emptied
    task automatic wait_drained;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_count != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Append one byte to the frame under construction
    task automatic frame_add(input logic [BYTE_W-1:0] v);
        frame_q.insert(frame_q.size(), v);
    endtask

    // Assemble sync, header, stuffed body and checksum into frame_q
    task automatic build_frame(input logic [INDEX_W-1:0] len, input frame_flaw_e flaw);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int count;
        int k;
        int break_at;
        bit aborted;
        sum      = '0;
        count    = 0;
        k        = 0;
        aborted  = 1'b0;
        break_at = $urandom_range(0, 5);
        frame_q.delete();
        frame_add(SYNC_FIRST);
        b = $urandom_range(0, 255);
        if (b == SYNC_SECOND) b = SYNC_FIRST;
        frame_add((flaw == FLAW_BAD_SYNC2) ? b : SYNC_SECOND);
        frame_add(len[7:0]);
        b = (flaw == FLAW_BLANK1) ? $urandom_range(1, 255) : 0;
        frame_add(b);
        frame_add(len[15:8]);
        b = (flaw == FLAW_BLANK2) ? $urandom_range(1, 255) : 0;
        frame_add(b);
        while (count < len && !aborted) begin
            b = ($urandom_range(0, 5) == 0) ? SYNC_FIRST : $urandom_range(0, 255);
            if (flaw == FLAW_NO_FILLER && k == break_at) b = SYNC_FIRST;
            frame_add(b);
            sum += b;
            count++;
            if (b == SYNC_FIRST) begin
                if (flaw == FLAW_NO_FILLER && k == break_at) begin
                    b = $urandom_range(0, 255);
                    if (b == FILLER_BYTE) b = 8'h00;
                    frame_add(b);
                    aborted = 1'b1;
                end else begin
                    frame_add(FILLER_BYTE);
                    sum += FILLER_BYTE;
                    count++;
                end
            end
            k++;
        end
        if (!aborted && len != 0) begin
            if (flaw == FLAW_BAD_SUM) sum += $urandom_range(1, 255);
            frame_add(sum);
        end
    endtask

    // Raw bypass: sometimes switched on mid-frame, sometimes ended by the last-ack flag
    task automatic raw_phase;
        logic [CFG_DW-1:0] w;
        int split;
        int n;
        split = 0;
        if ($urandom_range(0, 1)) begin
            build_frame($urandom_range(1, 10), FLAW_NONE);
            split = $urandom_range(1, frame_q.size() - 1);
            send_queued(0, split);
        end
        wait_drained();
        w = $urandom_range(0, 255);
        write_reg(CFG_RAW_TRANS, w);
        w = $urandom_range(0, 255) & 8'hFE;
        write_reg(CFG_RAW_LAST, w);
        w = $urandom_range(0, 255) | 8'h01;
        write_reg(CFG_RAW_MODE, w);
        if (split > 0) send_queued(split, frame_q.size());
        n = $urandom_range(1, 12);
        repeat (n) send_byte($urandom_range(0, 255));
        sent_items += n;
        wait_drained();
        if ($urandom_range(0, 1)) begin
            // the next byte is the last raw one; framing resumes right after it
            w = $urandom_range(0, 255) | 8'h01;
            write_reg(CFG_RAW_LAST, w);
            send_byte($urandom_range(0, 255));
            sent_items++;
            build_frame($urandom_range(1, 12), FLAW_NONE);
            send_queued(0, frame_q.size());
        end else begin
            w = $urandom_range(0, 255) & 8'hFE;
            write_reg(CFG_RAW_MODE, w);
        end
    endtask

    // Run limit
    initial begin
        #2000000;
        $display("sync_stuffed_packet_deframer regression: fail");
        $finish;
    end

    initial begin
        logic [INDEX_W-1:0] len;
        frame_flaw_e flaw;
        int pick;
        int r;
        int n;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Good frame ending on a stuffed sync byte, with 0xFF and 0x00 body values;
        // the result side holds off meanwhile
        hold_requests <= hold_requests + 1;
        frame_q = '{SYNC_FIRST, SYNC_SECOND, 8'h04, 8'h00, 8'h00, 8'h00,
                    8'hFF, 8'h00, SYNC_FIRST, FILLER_BYTE, 8'hFE};
        send_queued(0, frame_q.size());
        // second sync byte repeated as first: not rechecked
        frame_q = '{SYNC_FIRST, SYNC_FIRST, SYNC_SECOND};
        send_queued(0, frame_q.size());
        // zero length header
        frame_q = '{SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'h00, 8'h00};
        send_queued(0, frame_q.size());
        // raw mode with all-ones id and upper data bits set; first raw byte is the last ack
        wait_drained();
        write_reg(CFG_RAW_TRANS, 8'hFF);
        write_reg(CFG_RAW_LAST, 8'hFF);
        write_reg(CFG_RAW_MODE, 8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        sent_items += 2;
        wait_drained();
        write_reg(CFG_RAW_TRANS, 8'h00);

        // Random part: mostly frames with random content, some of them flawed
        while (sent_items < 2000) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                r = $urandom_range(0, 15);
                case (r)
                    0:       flaw = FLAW_BAD_SYNC2;
                    1:       flaw = FLAW_BLANK1;
                    2:       flaw = FLAW_BLANK2;
                    3:       flaw = FLAW_ZERO_LEN;
                    4:       flaw = FLAW_NO_FILLER;
                    5, 6, 7: flaw = FLAW_BAD_SUM;
                    default: flaw = FLAW_NONE;
                endcase
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    len = $urandom_range(17, 300);
                end else if (r == 1) begin
                    // long declared length, cut short by a missing filler
                    len  = $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(0, 65535);
                    flaw = FLAW_NO_FILLER;
                end else begin
                    len = $urandom_range(1, 16);
                end
                if (flaw == FLAW_ZERO_LEN) len = '0;
                build_frame(len, flaw);
                send_queued(0, frame_q.size());
            end else if (pick < 16) begin
                // line noise, biased toward framing bytes
                n = $urandom_range(1, 6);
                repeat (n) begin
                    case ($urandom_range(0, 4))
                        0:       send_byte(SYNC_FIRST);
                        1:       send_byte(SYNC_SECOND);
                        2:       send_byte(8'h00);
                        3:       send_byte(FILLER_BYTE);
                        default: send_byte($urandom_range(0, 255));
                    endcase
                end
                sent_items += n;
            end else if (pick < 18) begin
                raw_phase();
            end else if (pick == 18) begin
                hold_requests <= hold_requests + 1;
                build_frame($urandom_range(16, 40), FLAW_NONE);
                send_queued(0, frame_q.size());
            end else begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("sync_stuffed_packet_deframer regression: pass");
        end else begin
            $display("sync_stuffed_packet_deframer regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/spdf_pkg.sv
design/spdf_fsm.sv
design/sync_stuffed_packet_deframer.sv
verif/spdf_checker.sv
verif/tb_top.sv
